@@ rtl/lsbx_pkg.sv @@
// Package of the LSB hidden-data extractor: parse phases, result kinds,
// register indexes, reset values and the result and parser output structs.
// No dependencies; every other file of the block depends on it.
package lsbx_pkg;

   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 8;

   localparam logic [CsrIndexWidth-1:0] CSR_HEADER_LENGTH = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_MAGIC_FIRST   = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_MAGIC_SECOND  = 2'd2;

   localparam logic [7:0] HeaderLengthReset = 8'd54;
   localparam logic [7:0] MagicFirstReset   = 8'd35;
   localparam logic [7:0] MagicSecondReset  = 8'd42;

   localparam logic [31:0] ExtLenMin = 32'd2;
   localparam logic [31:0] ExtLenMax = 32'd4;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_MAGIC,
      PH_EXT_LEN,
      PH_EXT,
      PH_PAY_LEN,
      PH_PAY,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      KIND_EXT,
      KIND_PAY,
      KIND_BAD_MAGIC,
      KIND_BAD_EXT_LEN,
      KIND_EMPTY
   } kind_type;

   typedef struct packed {
      logic [7:0] hidden_byte;
      kind_type   item_kind;
      logic       is_last;
   } result_type;

   typedef struct packed {
      logic       emit;
      result_type result;
   } parse_out_type;

endpackage

@@ rtl/lsbx_ifs.sv @@
// Channel interfaces of the LSB hidden-data extractor: image byte requests
// and recovered result transactions. Depends on lsbx_pkg for the kind type.
interface lsbx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] image_byte;
   logic       file_start;

   modport source (output valid, output image_byte, output file_start, input ready);
   modport sink   (input valid, input image_byte, input file_start, output ready);
endinterface

interface lsbx_rsp_if;
   logic              valid;
   logic              ready;
   logic [7:0]        hidden_byte;
   lsbx_pkg::kind_type item_kind;
   logic              is_last;

   modport source (output valid, output hidden_byte, output item_kind, output is_last,
                   input ready);
   modport sink   (input valid, input hidden_byte, input item_kind, input is_last,
                   output ready);
endinterface

@@ rtl/lsb_stego_bmp_extractor.sv @@
// Top level of the LSB hidden-data extractor: configuration registers,
// input register, result register and the parser. Depends on lsbx_pkg,
// lsbx_ifs and lsbx_parser.
//
// Image file bytes arrive on the req channel, one per transaction, with
// file_start set on the first byte of each file. Recovered bytes and status
// results leave on the rsp channel as transactions carrying hidden_byte,
// item_kind and is_last. Most image bytes produce no result.
// Registers are written through the csr port (write enable, index, data);
// the user is to write them only while the block is idle, which the block
// itself does not enforce; an index beyond the register list is ignored.
// An accepted byte is held in the input register, parsed from there, and its
// result, if any, is registered onto rsp. One byte is taken every cycle
// while rsp flows. If the receiver holds rsp.ready low, the waiting result
// stays in the result register and one further byte may enter the input
// register; after that req.ready falls until the result is taken.
// Reset clears the parse state, empties both registers and restores the
// registers to a header length of 54 and magic bytes 35 and 42.
module lsb_stego_bmp_extractor (
   input  logic                              clock,
   input  logic                              reset,
   lsbx_req_if.sink                          req,
   lsbx_rsp_if.source                        rsp,
   input  logic                              csr_we,
   input  logic [lsbx_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [lsbx_pkg::CsrDataWidth-1:0]  csr_wdata
);
   import lsbx_pkg::*;

   logic [7:0]    header_length_ff;
   logic [7:0]    magic_first_ff;
   logic [7:0]    magic_second_ff;

   logic          in_valid_ff;
   logic [7:0]    in_byte_ff;
   logic          in_start_ff;
   logic          out_valid_ff;
   result_type    out_result_ff;

   logic          advance;
   parse_out_type parse_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_length_ff <= HeaderLengthReset;
         magic_first_ff   <= MagicFirstReset;
         magic_second_ff  <= MagicSecondReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HEADER_LENGTH: header_length_ff <= csr_wdata;
            CSR_MAGIC_FIRST:   magic_first_ff   <= csr_wdata;
            CSR_MAGIC_SECOND:  magic_second_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff  <= req.image_byte;
         in_start_ff <= req.file_start;
      end
   end

   lsbx_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .image_byte    (in_byte_ff),
      .file_start    (in_start_ff),
      .header_length (header_length_ff),
      .magic_first   (magic_first_ff),
      .magic_second  (magic_second_ff),
      .parse_out     (parse_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= parse_out.emit;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && parse_out.emit) begin
         out_result_ff <= parse_out.result;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.hidden_byte = out_result_ff.hidden_byte;
   assign rsp.item_kind   = out_result_ff.item_kind;
   assign rsp.is_last     = out_result_ff.is_last;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> in_valid_ff && out_valid_ff && !rsp.ready)
      else $error("Input stalled while a register was free.");

   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_result_ff.item_kind == KIND_BAD_MAGIC ||
                       out_result_ff.item_kind == KIND_BAD_EXT_LEN ||
                       out_result_ff.item_kind == KIND_EMPTY)
      |-> out_result_ff.is_last && out_result_ff.hidden_byte == 8'd0)
      else $error("Status result without end mark or with a non-zero byte.");

   a_ext_not_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_result_ff.item_kind == KIND_EXT |-> !out_result_ff.is_last)
      else $error("Extension byte marked as last.");

endmodule

@@ rtl/lsbx_parser.sv @@
// Parse state of the LSB hidden-data extractor: header skip, bit gathering,
// magic check, length fields and byte counting. Depends on lsbx_pkg.
module lsbx_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              image_byte,
   input  logic                    file_start,
   input  logic [7:0]              header_length,
   input  logic [7:0]              magic_first,
   input  logic [7:0]              magic_second,
   output lsbx_pkg::parse_out_type parse_out
);
   import lsbx_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  header_count_ff, header_count_in;
   logic [2:0]  bit_count_ff, bit_count_in;
   logic [7:0]  bit_shifter_ff, bit_shifter_in;
   logic [1:0]  field_index_ff, field_index_in;
   logic [31:0] length_acc_ff, length_acc_in;
   logic [31:0] remaining_ff, remaining_in;
   logic [7:0]  first_magic_ff, first_magic_in;

   always_comb begin
      logic        go;
      logic        length_done;
      logic [7:0]  hidden;
      logic [31:0] placed;

      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      bit_count_in    = bit_count_ff;
      bit_shifter_in  = bit_shifter_ff;
      field_index_in  = field_index_ff;
      length_acc_in   = length_acc_ff;
      remaining_in    = remaining_ff;
      first_magic_in  = first_magic_ff;
      parse_out       = '0;
      go              = 1'b0;
      length_done     = 1'b0;
      hidden          = '0;
      placed          = '0;

      if (file_start) begin
         phase_in        = PH_HEADER;
         header_count_in = '0;
         bit_count_in    = '0;
         bit_shifter_in  = '0;
         field_index_in  = '0;
         length_acc_in   = '0;
         remaining_in    = '0;
         first_magic_in  = '0;
      end

      if (phase_in != PH_DONE) begin
         go = 1'b1;
         if (phase_in == PH_HEADER) begin
            if (header_count_in < header_length) begin
               header_count_in = header_count_in + 8'd1;
               go = 1'b0;
            end else begin
               phase_in       = PH_MAGIC;
               field_index_in = '0;
            end
         end
      end

      if (go) begin
         hidden = {bit_shifter_in[6:0], image_byte[0]};
         if (bit_count_in != 3'd7) begin
            bit_count_in   = bit_count_in + 3'd1;
            bit_shifter_in = hidden;
            go = 1'b0;
         end else begin
            bit_count_in   = '0;
            bit_shifter_in = '0;
         end
      end

      if (go) begin
         placed = {24'd0, hidden} << {field_index_in, 3'b000};
         if (phase_in == PH_EXT_LEN || phase_in == PH_PAY_LEN) begin
            length_acc_in = length_acc_in | placed;
            length_done   = (field_index_in == 2'd3);
            field_index_in = field_index_in + 2'd1;
         end
         unique case (phase_in)
            PH_MAGIC: begin
               if (field_index_in == 2'd0) begin
                  first_magic_in = hidden;
                  field_index_in = 2'd1;
               end else begin
                  field_index_in = 2'd0;
                  if (first_magic_in == magic_first && hidden == magic_second) begin
                     phase_in      = PH_EXT_LEN;
                     length_acc_in = '0;
                  end else begin
                     phase_in = PH_DONE;
                     parse_out.emit = 1'b1;
                     parse_out.result.item_kind = KIND_BAD_MAGIC;
                     parse_out.result.is_last = 1'b1;
                  end
               end
            end
            PH_EXT_LEN: begin
               if (length_done) begin
                  if (length_acc_in < ExtLenMin || length_acc_in > ExtLenMax) begin
                     phase_in = PH_DONE;
                     parse_out.emit = 1'b1;
                     parse_out.result.item_kind = KIND_BAD_EXT_LEN;
                     parse_out.result.is_last = 1'b1;
                  end else begin
                     remaining_in  = length_acc_in;
                     length_acc_in = '0;
                     phase_in      = PH_EXT;
                  end
               end
            end
            PH_EXT: begin
               remaining_in = remaining_in - 32'd1;
               if (remaining_in == '0) begin
                  phase_in = PH_PAY_LEN;
               end
               parse_out.emit = 1'b1;
               parse_out.result.hidden_byte = hidden;
               parse_out.result.item_kind = KIND_EXT;
            end
            PH_PAY_LEN: begin
               if (length_done) begin
                  if (length_acc_in == '0) begin
                     phase_in = PH_DONE;
                     parse_out.emit = 1'b1;
                     parse_out.result.item_kind = KIND_EMPTY;
                     parse_out.result.is_last = 1'b1;
                  end else begin
                     remaining_in  = length_acc_in;
                     length_acc_in = '0;
                     phase_in      = PH_PAY;
                  end
               end
            end
            PH_PAY: begin
               remaining_in = remaining_in - 32'd1;
               parse_out.emit = 1'b1;
               parse_out.result.hidden_byte = hidden;
               parse_out.result.item_kind = KIND_PAY;
               if (remaining_in == '0) begin
                  phase_in = PH_DONE;
                  parse_out.result.is_last = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         header_count_ff <= '0;
         bit_count_ff    <= '0;
         bit_shifter_ff  <= '0;
         field_index_ff  <= '0;
         length_acc_ff   <= '0;
         remaining_ff    <= '0;
         first_magic_ff  <= '0;
      end else if (step) begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         bit_count_ff    <= bit_count_in;
         bit_shifter_ff  <= bit_shifter_in;
         field_index_ff  <= field_index_in;
         length_acc_ff   <= length_acc_in;
         remaining_ff    <= remaining_in;
         first_magic_ff  <= first_magic_in;
      end
   end

endmodule
